// ----- rtl/tmad_pkg.sv -----
// Shared types and constants for the trimmed-mean ADC decimator.
// No dependencies; imported by every module of the block.
package tmad_pkg;

   localparam int SAMPLE_BITS      = 12;
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int WIN_SUM_W        = 17;
   localparam int SEEN_W           = 6;
   localparam int LONG_W           = 20;
   localparam int TALLY_W          = 9;
   localparam int LOG2_W           = 4;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 12;

   localparam logic [SEEN_W-1:0]    SEEN_MAX    = 6'd63;
   localparam logic [SEEN_W:0]      WIN_LAST    = 7'd17;
   localparam logic [WIN_SUM_W-1:0] WIN_SUM_MAX = 17'h1FFFF;
   localparam logic [LOG2_W-1:0]    AVG_LOG2_MAX = 4'd8;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_SAMPLES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AVG_LOG2        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VALID_THRESHOLD = 2'd3;

   // closed window handed from the window stage to the accumulator stage
   typedef struct packed {
      logic [WIN_SUM_W-1:0]   sum;
      logic [SAMPLE_BITS-1:0] max;
      logic [SAMPLE_BITS-1:0] min;
   } close_type;

   // one result word, channel travels beside it
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] block_value;
      logic [SAMPLE_BITS-1:0] average_value;
      logic                   average_ready;
      logic                   above_threshold;
   } result_type;

endpackage

// ----- rtl/tmad_window.sv -----
// Window stage: settling skip, saturating sum, max/min tracking, channel rotation.
// Depends on tmad_pkg; holds the closed-window record for tmad_accum.
module tmad_window #(
   parameter int MAX_CHANNELS = tmad_pkg::MAX_CHANNELS_DEF,
   parameter int CH_W         = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sample_accept,
   input  logic [tmad_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [3:0]                    channel_count,
   input  logic [3:0]                    settle_samples,
   input  logic                          rec_take,
   output logic                          rec_valid,
   output logic [CH_W-1:0]               rec_channel,
   output tmad_pkg::close_type           rec
);
   import tmad_pkg::*;

   logic [SEEN_W-1:0]      seen_ff, seen_in;
   logic [CH_W-1:0]        chan_ff, chan_in;
   logic [WIN_SUM_W-1:0]   sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic                   rec_valid_ff, rec_valid_in;
   logic [CH_W-1:0]        rec_channel_ff;
   close_type              rec_ff;

   logic                   in_window;
   logic                   closes;
   logic [WIN_SUM_W:0]     sum_wide;
   logic [WIN_SUM_W-1:0]   sum_upd;
   logic [SAMPLE_BITS-1:0] max_upd, min_upd;
   logic [CH_W-1:0]        chan_cur;
   logic [4:0]             cnt_eff;
   logic [4:0]             chan_plus;

   always_comb begin
      in_window = ({1'b0, seen_ff} >= {3'b000, settle_samples});
      closes    = ({1'b0, seen_ff} >= ({3'b000, settle_samples} + WIN_LAST));

      sum_wide = {1'b0, sum_ff} + {{(WIN_SUM_W + 1 - SAMPLE_BITS){1'b0}}, sample};
      sum_upd  = sum_ff;
      max_upd  = max_ff;
      min_upd  = min_ff;
      if (in_window) begin
         sum_upd = sum_wide[WIN_SUM_W] ? WIN_SUM_MAX : sum_wide[WIN_SUM_W-1:0];
         if (sample > max_ff) max_upd = sample;
         if (sample < min_ff) min_upd = sample;
      end

      // a channel index past the table wraps to channel zero
      chan_cur = (int'(chan_ff) >= MAX_CHANNELS) ? '0 : chan_ff;

      if (channel_count == 4'd0) begin
         cnt_eff = 5'd1;
      end else if (int'(channel_count) > MAX_CHANNELS) begin
         cnt_eff = 5'(MAX_CHANNELS);
      end else begin
         cnt_eff = {1'b0, channel_count};
      end
      chan_plus = 5'(chan_cur) + 5'd1;

      seen_in = seen_ff;
      chan_in = chan_ff;
      sum_in  = sum_ff;
      max_in  = max_ff;
      min_in  = min_ff;
      if (sample_accept) begin
         if (closes) begin
            seen_in = '0;
            sum_in  = '0;
            max_in  = '0;
            min_in  = '1;
            chan_in = (chan_plus >= cnt_eff) ? '0 : chan_plus[CH_W-1:0];
         end else begin
            seen_in = (seen_ff < SEEN_MAX) ? seen_ff + 6'd1 : seen_ff;
            sum_in  = sum_upd;
            max_in  = max_upd;
            min_in  = min_upd;
         end
      end

      // load wins over take: a fresh record replaces the one leaving
      if (sample_accept && closes) begin
         rec_valid_in = 1'b1;
      end else if (rec_take) begin
         rec_valid_in = 1'b0;
      end else begin
         rec_valid_in = rec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         chan_ff      <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
         min_ff       <= '1;
         rec_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         chan_ff      <= chan_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_accept && closes) begin
         rec_ff.sum     <= sum_upd;
         rec_ff.max     <= max_upd;
         rec_ff.min     <= min_upd;
         rec_channel_ff <= chan_cur;
      end
   end

   assign rec_valid   = rec_valid_ff;
   assign rec_channel = rec_channel_ff;
   assign rec         = rec_ff;

endmodule

// ----- rtl/tmad_accum.sv -----
// Accumulator stage: trims the extremes, forms the block value, keeps the
// per-channel long sums and tallies. Depends on tmad_pkg.
module tmad_accum #(
   parameter int MAX_CHANNELS = tmad_pkg::MAX_CHANNELS_DEF,
   parameter int CH_W         = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rec_take,
   input  logic [CH_W-1:0]                  rec_channel,
   input  tmad_pkg::close_type              rec,
   input  logic [3:0]                       avg_log2,
   input  logic [tmad_pkg::SAMPLE_BITS-1:0] valid_threshold,
   output tmad_pkg::result_type             result
);
   import tmad_pkg::*;

   logic [LONG_W-1:0]  long_sum_ff [MAX_CHANNELS];
   logic [TALLY_W-1:0] tally_ff    [MAX_CHANNELS];

   logic [SAMPLE_BITS:0]   extremes;
   logic [WIN_SUM_W-1:0]   trimmed;
   logic [SAMPLE_BITS-1:0] block_value;
   logic [LOG2_W-1:0]      shift;
   logic [LONG_W-1:0]      long_new;
   logic [TALLY_W-1:0]     tally_new;
   logic                   ready;
   logic [LONG_W-1:0]      long_shifted;

   always_comb begin
      extremes = {1'b0, rec.max} + {1'b0, rec.min};
      trimmed  = (rec.sum > WIN_SUM_W'(extremes))
                 ? rec.sum - WIN_SUM_W'(extremes) : '0;
      // drop four bits, saturate anything left above twelve
      block_value = trimmed[WIN_SUM_W-1] ? '1 : trimmed[SAMPLE_BITS+3:4];

      shift     = (avg_log2 > AVG_LOG2_MAX) ? AVG_LOG2_MAX : avg_log2;
      long_new  = long_sum_ff[rec_channel] + LONG_W'(block_value);
      tally_new = tally_ff[rec_channel] + 9'd1;
      ready     = ({1'b0, tally_new} >= (10'd1 << shift));
      long_shifted = long_new >> shift;

      result.block_value     = block_value;
      result.average_value   = ready ? long_shifted[SAMPLE_BITS-1:0] : '0;
      result.average_ready   = ready;
      result.above_threshold = (block_value > valid_threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            long_sum_ff[i] <= '0;
            tally_ff[i]    <= '0;
         end
      end else if (rec_take) begin
         long_sum_ff[rec_channel] <= ready ? '0 : long_new;
         tally_ff[rec_channel]    <= ready ? '0 : tally_new;
      end
   end

endmodule

// ----- rtl/trimmed_mean_adc_decimator_core.sv -----
// Top level of the trimmed-mean ADC decimator: config registers, handshake,
// result register. Depends on tmad_pkg, tmad_window and tmad_accum.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_sample
//   rsp_     out        rsp_valid/rsp_stall  rsp_channel, rsp_block_value,
//                                            rsp_average_value, rsp_average_ready,
//                                            rsp_above_threshold
//   csr_     in         csr_write_en         csr_index, csr_wdata
//
// One sample per cycle while req_stall is low. The sample that closes a window loads
// the record at the edge that takes it; its result word moves from the record onto
// rsp_ once the result register is empty or leaving.
// Synchronous reset clears the window, the per-channel accumulators at once,
// and loads channel_count 3, settle_samples 2, avg_log2 8, valid_threshold 729.
// req_stall rises only when a closed-window record waits behind a stalled
// result word.
module trimmed_mean_adc_decimator_core #(
   parameter int MAX_CHANNELS = tmad_pkg::MAX_CHANNELS_DEF,
   parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tmad_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [CH_W-1:0]                  rsp_channel,
   output logic [tmad_pkg::SAMPLE_BITS-1:0] rsp_block_value,
   output logic [tmad_pkg::SAMPLE_BITS-1:0] rsp_average_value,
   output logic                             rsp_average_ready,
   output logic                             rsp_above_threshold,
   input  logic                             csr_write_en,
   input  logic [tmad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tmad_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tmad_pkg::*;

   logic [3:0]             channel_count_ff;
   logic [3:0]             settle_samples_ff;
   logic [3:0]             avg_log2_ff;
   logic [SAMPLE_BITS-1:0] valid_threshold_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]        rsp_channel_ff;
   result_type             rsp_result_ff;

   logic                   sample_accept;
   logic                   rec_valid;
   logic                   rec_take;
   logic [CH_W-1:0]        rec_channel;
   close_type              rec;
   result_type             result;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff   <= 4'd3;
         settle_samples_ff  <= 4'd2;
         avg_log2_ff        <= 4'd8;
         valid_threshold_ff <= 12'd729;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_CHANNEL_COUNT:   channel_count_ff   <= csr_wdata[3:0];
            REG_SETTLE_SAMPLES:  settle_samples_ff  <= csr_wdata[3:0];
            REG_AVG_LOG2:        avg_log2_ff        <= csr_wdata[3:0];
            REG_VALID_THRESHOLD: valid_threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // advance the record into the result register whenever that register is empty or its word leaves
   assign rec_take      = rec_valid && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = rec_valid && !rec_take;
   assign sample_accept = req_valid && !req_stall;

   tmad_window #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .CH_W         (CH_W)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .sample_accept  (sample_accept),
      .sample         (req_sample),
      .channel_count  (channel_count_ff),
      .settle_samples (settle_samples_ff),
      .rec_take       (rec_take),
      .rec_valid      (rec_valid),
      .rec_channel    (rec_channel),
      .rec            (rec)
   );

   tmad_accum #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .CH_W         (CH_W)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .rec_take        (rec_take),
      .rec_channel     (rec_channel),
      .rec             (rec),
      .avg_log2        (avg_log2_ff),
      .valid_threshold (valid_threshold_ff),
      .result          (result)
   );

   always_comb begin
      if (rec_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         rsp_channel_ff <= rec_channel;
         rsp_result_ff  <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel         = rsp_channel_ff;
   assign rsp_block_value     = rsp_result_ff.block_value;
   assign rsp_average_value   = rsp_result_ff.average_value;
   assign rsp_average_ready   = rsp_result_ff.average_ready;
   assign rsp_above_threshold = rsp_result_ff.above_threshold;

   a_take_fills_rsp : assert property (@(posedge clock) disable iff (reset)
      rec_take |=> rsp_valid)
      else $error("record taken but no result word followed");

   a_avg_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_average_ready) |-> (rsp_average_value == '0))
      else $error("average value nonzero without average ready");

   a_channel_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_channel) < MAX_CHANNELS))
      else $error("result channel out of range");

   a_no_stall_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while the result side can move");

endmodule
